[hw/rtl/tsr_pkg.sv]
// Shared types and constants for the TCP segment reorder table.
package tsr_pkg;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd3;
	localparam logic [2:0] ST_IDLE      = 3'd4;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_FLUSH  = 1'b1;

	typedef struct packed {
		logic [31:0] seq_number;
		logic [15:0] segment_length;
		logic [7:0]  buffer_handle;
		logic        syn_flag;
		logic        fin_flag;
	} seg_t;

	typedef struct packed {
		logic        result_kind;
		logic [2:0]  insert_status;
		logic [7:0]  out_handle;
		logic [31:0] out_seq;
		logic [15:0] out_length;
		logic        gap_flag;
		logic [31:0] expected_seq;
		logic        last_result;
	} res_t;

	// Entry stored in the table memory.
	typedef struct packed {
		logic [31:0] seq;
		logic [15:0] len;
		logic [7:0]  handle;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Command word passed from the front to the back through the queue.
	typedef struct packed {
		logic        start;    // SYN on an idle stream: reinitialize first
		logic        active;   // stream active after the SYN check
		seg_t        seg;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_SHIFT,
		BK_STATUS,
		BK_FLUSH_RD,
		BK_FLUSH_OUT
	} bk_state_t;

endpackage

[hw/rtl/tsr_stream_if.sv]
// Valid/ready channel interface carrying one word of a given width.
interface tsr_stream_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/tcp_segment_reorder_table_unit.sv]
// Top level of the TCP segment reorder table: front queue plus table back end.
// A status word is registered in BK_STATUS for idle, zero-length or full
// segments; a sorted insert first searches and moves entries, reading each
// one before comparing or writing it. A FIN flush reads each entry, then emits
// its descriptor. The back end takes one segment at a time, only when idle.
// Reset: stream idle, table empty; table memory contents are not cleared.
module tcp_segment_reorder_table_unit #(
	parameter int MAX_SEGMENTS = 32
) (
	input logic clk,
	input logic arst_n,
	tsr_stream_if.sink   seg_in,
	tsr_stream_if.source res_out
);
	// The front tracks SYN/FIN so it can classify each word before the back
	// end sees it; the two-deep queue lets inputs land while a flush drains.
	tsr_pkg::cmd_t cmd_data;
	logic          cmd_valid, cmd_ready;

	tsr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_seg(seg_in),
		.cmd_data(cmd_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
	);

	// The back end performs the sorted search, shift and ordered flush.
	tsr_back #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_data(cmd_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
		.res(res_out)
	);
endmodule

[hw/rtl/tsr_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
module tsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[hw/rtl/tsr_front.sv]
// Front end: accepts segment words, tracks stream activity and queues commands.
module tsr_front (
	input  logic  clk,
	input  logic  arst_n,
	tsr_stream_if.sink in_seg,
	output tsr_pkg::cmd_t cmd_data,
	output logic  cmd_valid,
	input  logic  cmd_ready
);
	// Two-entry queue.
	tsr_pkg::cmd_t q_q [2];
	logic          rd_ptr_q, wr_ptr_q;
	logic [1:0]    cnt_q;
	logic          active_q;
	tsr_pkg::seg_t seg;
	tsr_pkg::cmd_t cmd_new;
	logic          push, pop;

	assign seg          = in_seg.data;
	assign in_seg.ready = (cnt_q != 2'd2);
	assign push         = in_seg.valid && in_seg.ready;
	assign pop          = cmd_valid && cmd_ready;
	assign cmd_valid    = (cnt_q != 2'd0);
	assign cmd_data     = q_q[rd_ptr_q];

	always_comb begin
		cmd_new.seg    = seg;
		cmd_new.start  = seg.syn_flag && !active_q;
		cmd_new.active = active_q || seg.syn_flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			active_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
				// A FIN on an active stream flushes and returns to idle.
				active_q <= cmd_new.active && !seg.fin_flag;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cmd_new;
		end
	end
endmodule

[hw/rtl/tsr_back.sv]
// Back end: sorted insertion into the table memory and in-order flush.
module tsr_back #(
	parameter int MAX_SEGMENTS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tsr_pkg::cmd_t cmd_data,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	tsr_stream_if.source  res
);
	localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);

	tsr_pkg::bk_state_t state_q, state_d;
	tsr_pkg::cmd_t      cmd_q;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [31:0]        start_q, start_d;
	logic [31:0]        expect_q, expect_d;
	logic [2:0]         status_q, status_d;
	logic               rd_pend_q, rd_pend_d;
	tsr_pkg::res_t      out_q, out_d;
	logic               out_v_q, out_v_d;

	logic               we;
	logic [AW-1:0]      waddr, raddr;
	tsr_pkg::entry_t    wdata, rdata;
	tsr_pkg::entry_t    new_e;

	tsr_ram #(.WIDTH(tsr_pkg::ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign res.valid = out_v_q;
	assign res.data  = out_q;
	assign new_e     = '{seq: cmd_q.seg.seq_number, len: cmd_q.seg.segment_length,
		handle: cmd_q.seg.buffer_handle};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tsr_pkg::BK_IDLE;
			count_q   <= '0;
			start_q   <= '0;
			out_v_q   <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			start_q   <= start_d;
			out_v_q   <= out_v_d;
			rd_pend_q <= rd_pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd_data;
		end
		idx_q    <= idx_d;
		expect_q <= expect_d;
		status_q <= status_d;
		out_q    <= out_d;
	end

	// Search walks upward from entry 0, reading each entry and then comparing it;
	// shift works down from the top, reading each entry, then writing it one higher.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		start_d   = start_q;
		expect_d  = expect_q;
		status_d  = status_q;
		rd_pend_d = 1'b0;
		out_d     = out_q;
		out_v_d   = out_v_q && !res.ready;
		cmd_ready = 1'b0;
		we        = 1'b0;
		waddr     = idx_q[AW-1:0];
		wdata     = new_e;
		raddr     = idx_q[AW-1:0];
		unique case (state_q)
			tsr_pkg::BK_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					idx_d     = '0;
					rd_pend_d = 1'b0;
					if (cmd_data.start) begin
						count_d = '0;
						start_d = cmd_data.seg.seq_number;
					end
					if (!cmd_data.active) begin
						status_d = tsr_pkg::ST_IDLE;
						state_d  = tsr_pkg::BK_STATUS;
					end else if (cmd_data.seg.segment_length == 16'd0) begin
						status_d = tsr_pkg::ST_ZERO_LEN;
						state_d  = tsr_pkg::BK_STATUS;
					end else if ((cmd_data.start ? {CW{1'b0}} : count_q) >= MAX_C) begin
						status_d = tsr_pkg::ST_FULL;
						state_d  = tsr_pkg::BK_STATUS;
					end else begin
						state_d = tsr_pkg::BK_SEARCH;
					end
				end
			end
			tsr_pkg::BK_SEARCH: begin
				if (idx_q == count_q) begin
					state_d = tsr_pkg::BK_SHIFT;
				end else if (!rd_pend_q) begin
					rd_pend_d = 1'b1;
				end else if (rdata.seq < new_e.seq) begin
					idx_d = idx_q + 1'b1;
				end else if (rdata.seq == new_e.seq) begin
					status_d = tsr_pkg::ST_DUPLICATE;
					state_d  = tsr_pkg::BK_STATUS;
				end else begin
					state_d = tsr_pkg::BK_SHIFT;
				end
				if (state_d == tsr_pkg::BK_SHIFT) begin
					// expect_q serves as the shift cursor: next slot to fill.
					expect_d = 32'(count_q);
				end
			end
			tsr_pkg::BK_SHIFT: begin
				raddr = AW'(expect_q[CW-1:0] - 1'b1);
				waddr = AW'(expect_q[CW-1:0]);
				if (expect_q[CW-1:0] == idx_q) begin
					we       = 1'b1;
					wdata    = new_e;
					count_d  = count_q + 1'b1;
					status_d = tsr_pkg::ST_INSERTED;
					state_d  = tsr_pkg::BK_STATUS;
				end else if (!rd_pend_q) begin
					rd_pend_d = 1'b1;
				end else begin
					we       = 1'b1;
					wdata    = rdata;
					expect_d = expect_q - 32'd1;
				end
			end
			tsr_pkg::BK_STATUS: begin
				if (!out_v_d) begin
					out_v_d             = 1'b1;
					out_d               = '0;
					out_d.result_kind   = tsr_pkg::KIND_STATUS;
					out_d.insert_status = status_q;
					idx_d               = '0;
					expect_d            = start_q;
					if (cmd_q.active && cmd_q.seg.fin_flag) begin
						out_d.last_result = (count_q == '0);
						start_d = '0;
						state_d = (count_q == '0) ? tsr_pkg::BK_IDLE : tsr_pkg::BK_FLUSH_RD;
						if (count_q == '0) begin
							count_d = '0;
						end
					end else begin
						out_d.last_result = 1'b1;
						state_d = tsr_pkg::BK_IDLE;
					end
				end
			end
			tsr_pkg::BK_FLUSH_RD: begin
				state_d = tsr_pkg::BK_FLUSH_OUT;
			end
			tsr_pkg::BK_FLUSH_OUT: begin
				if (!out_v_d) begin
					out_v_d            = 1'b1;
					out_d.result_kind  = tsr_pkg::KIND_FLUSH;
					out_d.insert_status = tsr_pkg::ST_INSERTED;
					out_d.out_handle   = rdata.handle;
					out_d.out_seq      = rdata.seq;
					out_d.out_length   = rdata.len;
					out_d.gap_flag     = (rdata.seq != expect_q);
					out_d.expected_seq = expect_q;
					out_d.last_result  = (idx_q + 1'b1 == count_q);
					expect_d           = rdata.seq + 32'(rdata.len);
					idx_d              = idx_q + 1'b1;
					if (idx_q + 1'b1 == count_q) begin
						count_d = '0;
						state_d = tsr_pkg::BK_IDLE;
					end else begin
						state_d = tsr_pkg::BK_FLUSH_RD;
					end
				end
			end
			default: state_d = tsr_pkg::BK_IDLE;
		endcase
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_C) else $error("entry count above table size");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsr_pkg::BK_SHIFT && state_d == tsr_pkg::BK_STATUS) |=>
		count_q == $past(count_q) + 1'b1) else $error("insert did not grow count");
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tsr_pkg::BK_FLUSH_OUT && state_d == tsr_pkg::BK_IDLE) |=>
		count_q == '0) else $error("flush left entries");
	a_take_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> state_q == tsr_pkg::BK_IDLE) else $error("command taken while busy");
endmodule
